// ----- src/sps_pkg.sv -----
// Shared types, command codes and the coil phase table of the stepper position sequencer.
package sps_pkg;

    // Widths of the word fields.
    localparam int unsigned CMD_BITS   = 3;
    localparam int unsigned VALUE_BITS = 16;
    localparam int unsigned LIMIT_BITS = 15;
    localparam int unsigned COIL_BITS  = 4;
    localparam int unsigned OUT_BITS   = 16;
    localparam int unsigned HOLD_BITS  = 8;
    localparam int unsigned SPEED_BITS = 2;
    localparam int unsigned PHASE_BITS = 3;

    // Configuration port.
    localparam int unsigned CFG_INDEX_BITS = 2;
    localparam int unsigned CFG_DATA_BITS  = 8;

    // Register hold value after reset.
    localparam logic [HOLD_BITS-1:0] HOLD_TICKS_RESET = 8'd10;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_SPEED_MODE    = 2'd0,
        CFG_HOLD_TICKS    = 2'd1,
        CFG_TEST_INACTIVE = 2'd2,
        CFG_UNUSED        = 2'd3
    } cfg_index_t;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_TICK       = 3'd0,
        CMD_SET_TARGET = 3'd1,
        CMD_SET_POS    = 3'd2,
        CMD_ZERO_BOTH  = 3'd3,
        CMD_STOP       = 3'd4,
        CMD_OFFSET     = 3'd5,
        CMD_REARM      = 3'd6,
        CMD_NONE       = 3'd7
    } command_t;

    // Speed modes that run the tick divider.
    localparam logic [SPEED_BITS-1:0] SPEED_HALF  = 2'd1;
    localparam logic [SPEED_BITS-1:0] SPEED_THIRD = 2'd2;

    // Two-phase drive pattern, one entry per phase index.
    localparam logic [COIL_BITS-1:0] COIL_TABLE [8] = '{
        4'b0011, 4'b0110, 4'b1100, 4'b1001,
        4'b0011, 4'b0110, 4'b1100, 4'b1001
    };

    typedef struct packed {
        logic [CMD_BITS-1:0]          command;
        logic signed [VALUE_BITS-1:0] value;
        logic [LIMIT_BITS-1:0]        limit;
    } in_word_t;

    typedef struct packed {
        logic [COIL_BITS-1:0]       coils;
        logic signed [OUT_BITS-1:0] position;
        logic signed [OUT_BITS-1:0] target_pos;
        logic                       done_res;
        logic                       ok;
    } out_word_t;

    typedef struct packed {
        logic [SPEED_BITS-1:0] speed_mode;
        logic [HOLD_BITS-1:0]  hold_ticks;
        logic                  test_inactive;
    } cfg_t;

endpackage

// ----- src/sps_core.sv -----
// Motion state registers and the single-pass next-state logic for one command word.
module sps_core #(
    parameter int unsigned PHASE_COUNT = 8,
    parameter int unsigned POS_BITS    = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  sps_pkg::in_word_t word_in,
    input  sps_pkg::cfg_t     cfg,
    output sps_pkg::out_word_t result
);

    localparam int unsigned RW = POS_BITS + 1;
    localparam int unsigned WW =
        ((POS_BITS > sps_pkg::VALUE_BITS) ? POS_BITS : sps_pkg::VALUE_BITS) + 2;
    localparam int unsigned PHASE_BITS_P1 = sps_pkg::PHASE_BITS + 1;

    logic [POS_BITS-1:0]            target_reg, target_next;
    logic [POS_BITS-1:0]            position_reg, position_next;
    logic signed [RW-1:0]           remaining_reg, remaining_next;
    logic [sps_pkg::HOLD_BITS-1:0]  start_hold_reg, start_hold_next;
    logic [sps_pkg::HOLD_BITS-1:0]  stop_hold_reg, stop_hold_next;
    logic [sps_pkg::SPEED_BITS-1:0] divider_reg, divider_next;
    logic [sps_pkg::PHASE_BITS-1:0] phase_reg, phase_next;
    logic [sps_pkg::COIL_BITS-1:0]  coil_reg, coil_next;
    logic                           ok_next;

    logic signed [POS_BITS-1:0] target_s, position_s;
    logic signed [RW-1:0]       distance;
    logic signed [WW-1:0]       value_w, target_w, offset_sum, limit_w;
    logic [PHASE_BITS_P1-1:0]   phase_inc;
    logic [WW-1:0]              pos_z, tgt_z;

    assign target_s   = target_reg;
    assign position_s = position_reg;
    assign distance   = RW'(target_s) - RW'(position_s);
    assign value_w    = WW'(word_in.value);
    assign target_w   = WW'(target_s);
    assign offset_sum = target_w + value_w;
    assign limit_w    = WW'(word_in.limit);
    assign phase_inc  = {1'b0, phase_reg} + PHASE_BITS_P1'(1);

    always_comb
    begin
        logic skip;
        skip            = 1'b0;
        target_next     = target_reg;
        position_next   = position_reg;
        remaining_next  = remaining_reg;
        start_hold_next = start_hold_reg;
        stop_hold_next  = stop_hold_reg;
        divider_next    = divider_reg;
        phase_next      = phase_reg;
        coil_next       = coil_reg;
        ok_next         = 1'b1;
        if (step)
        begin
            case (sps_pkg::command_t'(word_in.command))
                sps_pkg::CMD_TICK:
                begin
                    if (!cfg.test_inactive)
                    begin
                        // Latch a new move when idle and off target.
                        if (remaining_reg == '0 && target_reg != position_reg)
                        begin
                            remaining_next  = distance;
                            start_hold_next = cfg.hold_ticks;
                            stop_hold_next  = cfg.hold_ticks;
                        end
                        if (cfg.speed_mode == sps_pkg::SPEED_HALF ||
                            cfg.speed_mode == sps_pkg::SPEED_THIRD)
                        begin
                            if (divider_reg != '0)
                            begin
                                divider_next = divider_reg - 2'd1;
                                skip         = 1'b1;
                            end
                            else
                            begin
                                divider_next = cfg.speed_mode;
                            end
                        end
                        if (!skip)
                        begin
                            if (start_hold_next != '0)
                            begin
                                start_hold_next = start_hold_next - 8'd1;
                                coil_next       = sps_pkg::COIL_TABLE[phase_reg];
                            end
                            else if (remaining_next == '0)
                            begin
                                if (stop_hold_next != '0)
                                begin
                                    stop_hold_next = stop_hold_next - 8'd1;
                                    coil_next      = sps_pkg::COIL_TABLE[phase_reg];
                                end
                                else
                                begin
                                    coil_next = '0;
                                end
                            end
                            else if (!remaining_next[RW-1])
                            begin
                                remaining_next = remaining_next - RW'(1);
                                position_next  = position_reg + POS_BITS'(1);
                                if (phase_inc >= PHASE_BITS_P1'(PHASE_COUNT))
                                    phase_next = '0;
                                else
                                    phase_next = phase_inc[sps_pkg::PHASE_BITS-1:0];
                                coil_next = sps_pkg::COIL_TABLE[phase_next];
                            end
                            else
                            begin
                                remaining_next = remaining_next + RW'(1);
                                position_next  = position_reg - POS_BITS'(1);
                                if (phase_reg == '0 ||
                                    {1'b0, phase_reg} >= PHASE_BITS_P1'(PHASE_COUNT))
                                    phase_next = sps_pkg::PHASE_BITS'(PHASE_COUNT - 1);
                                else
                                    phase_next = phase_reg - 3'd1;
                                coil_next = sps_pkg::COIL_TABLE[phase_next];
                            end
                        end
                    end
                end
                sps_pkg::CMD_SET_TARGET:
                    target_next = value_w[POS_BITS-1:0];
                sps_pkg::CMD_SET_POS:
                    position_next = value_w[POS_BITS-1:0];
                sps_pkg::CMD_ZERO_BOTH:
                begin
                    target_next   = '0;
                    position_next = '0;
                end
                sps_pkg::CMD_STOP:
                begin
                    target_next     = position_reg;
                    remaining_next  = '0;
                    start_hold_next = cfg.hold_ticks;
                    stop_hold_next  = cfg.hold_ticks;
                end
                sps_pkg::CMD_OFFSET:
                begin
                    remaining_next  = '0;
                    start_hold_next = cfg.hold_ticks;
                    stop_hold_next  = cfg.hold_ticks;
                    if (offset_sum > limit_w)
                    begin
                        target_next = limit_w[POS_BITS-1:0];
                        ok_next     = 1'b0;
                    end
                    else if (offset_sum[WW-1])
                    begin
                        target_next = '0;
                        ok_next     = 1'b0;
                    end
                    else
                    begin
                        target_next = offset_sum[POS_BITS-1:0];
                    end
                end
                sps_pkg::CMD_REARM:
                begin
                    start_hold_next = cfg.hold_ticks;
                    stop_hold_next  = cfg.hold_ticks;
                end
                default:
                begin
                    ok_next = 1'b1;
                end
            endcase
        end
    end

    // Report the low bits of the zero-extended next-state values.
    assign pos_z = WW'(position_next);
    assign tgt_z = WW'(target_next);

    always_comb
    begin
        result.coils      = coil_next;
        result.position   = pos_z[sps_pkg::OUT_BITS-1:0];
        result.target_pos = tgt_z[sps_pkg::OUT_BITS-1:0];
        result.done_res   = (position_next == target_next);
        result.ok         = ok_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg     <= '0;
            position_reg   <= '0;
            remaining_reg  <= '0;
            start_hold_reg <= '0;
            stop_hold_reg  <= '0;
            divider_reg    <= '0;
            phase_reg      <= '0;
            coil_reg       <= '0;
        end
        else
        begin
            target_reg     <= target_next;
            position_reg   <= position_next;
            remaining_reg  <= remaining_next;
            start_hold_reg <= start_hold_next;
            stop_hold_reg  <= stop_hold_next;
            divider_reg    <= divider_next;
            phase_reg      <= phase_next;
            coil_reg       <= coil_next;
        end
    end

endmodule

// ----- src/sps_out_stage.sv -----
// Result register that holds one finished word until the consumer takes it.
module sps_out_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  sps_pkg::out_word_t  load_data,
    output logic                can_load,
    output logic                out_valid,
    input  logic                out_ready,
    output sps_pkg::out_word_t  out_data
);

    logic               valid_reg, valid_next;
    sps_pkg::out_word_t data_reg;

    // Take a new word when the register is empty or the held one leaves in the same cycle.
    assign can_load   = !valid_reg || out_ready;
    assign valid_next = load || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= load_data;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ----- src/stepper_position_sequencer_unit.sv -----
// Top level of the stepper position sequencer: configuration registers, core and result register.
//
// Drives one four-coil stepper toward a target step position, one command word per item.
// Every accepted word produces exactly one result word carrying the coil drive, the position
// and target after the command, a done flag and a clamp flag. A word is accepted in any cycle
// in which the result register is empty or its word is being taken, so the block sustains one
// word per clock unless stalled; the whole update of the motion registers is one pass of logic
// from the accepted word into the motion and result registers, and a result appears in the cycle
// after acceptance. Tick words (command 0, test_inactive clear) advance the motion: latch a move
// when idle, apply the speed divider, then spend a start-hold tick, step one phase of the
// two-phase pattern, spend a stop-hold tick or switch the coils off. The other commands set the
// target, set the position, zero both, stop, offset the target clamped to 0..limit, or rearm the
// holds. Configuration writes (cfg_write, cfg_index, cfg_data) take effect at once and should
// be made only while no word is in flight: index 0 speed_mode, 1 hold_ticks, 2 test_inactive.
module stepper_position_sequencer_unit #(
    parameter int unsigned PHASE_COUNT = 8,
    parameter int unsigned POS_BITS    = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  sps_pkg::in_word_t                     in_data,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output sps_pkg::out_word_t                    out_data,
    input  logic                                  cfg_write,
    input  logic [sps_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [sps_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

    logic [sps_pkg::SPEED_BITS-1:0] speed_mode_reg;
    logic [sps_pkg::HOLD_BITS-1:0]  hold_ticks_reg;
    logic                           test_inactive_reg;

    sps_pkg::cfg_t      cfg;
    sps_pkg::out_word_t core_result;
    logic               accept;
    logic               can_load;

    // Configuration registers; an index beyond the list is dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_mode_reg    <= '0;
            hold_ticks_reg    <= sps_pkg::HOLD_TICKS_RESET;
            test_inactive_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (sps_pkg::cfg_index_t'(cfg_index))
                sps_pkg::CFG_SPEED_MODE:
                    speed_mode_reg <= cfg_data[sps_pkg::SPEED_BITS-1:0];
                sps_pkg::CFG_HOLD_TICKS:
                    hold_ticks_reg <= cfg_data[sps_pkg::HOLD_BITS-1:0];
                sps_pkg::CFG_TEST_INACTIVE:
                    test_inactive_reg <= cfg_data[0];
                default:
                    test_inactive_reg <= test_inactive_reg;
            endcase
        end
    end

    always_comb
    begin
        cfg.speed_mode    = speed_mode_reg;
        cfg.hold_ticks    = hold_ticks_reg;
        cfg.test_inactive = test_inactive_reg;
    end

    // Advance the motion state only on an accepted word.
    assign in_ready = can_load;
    assign accept   = in_valid && can_load;

    sps_core #(
        .PHASE_COUNT (PHASE_COUNT),
        .POS_BITS    (POS_BITS)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (accept),
        .word_in (in_data),
        .cfg     (cfg),
        .result  (core_result)
    );

    sps_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .load_data (core_result),
        .can_load  (can_load),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
